// ----- rtl/hcg_pkg.sv -----
// shared types, constants and the gamma table of the histogram contrast gain block
// used by every module under rtl; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package hcg_pkg;

  localparam int BINS        = 256;
  localparam int BIN_W       = 8;
  localparam int COUNT_BITS  = 24;
  localparam int TOTAL_W     = COUNT_BITS + BIN_W;
  localparam int THR_W       = TOTAL_W + PCT_W;
  localparam int PCT_W       = 7;
  localparam int GAIN_W      = 15;
  localparam int NUM_W       = TOTAL_W + PCT_W;
  localparam int DEN_W       = 16;
  localparam int DIV_CNT_W   = $clog2(NUM_W);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int CG_W        = 19;
  localparam int ALPHA_W     = 17;

  localparam int PCT_SCALE   = 100;
  localparam int CLIP_NUM    = 25344 * 1024;
  localparam int CG_NUM      = 262144;
  localparam logic [GAIN_W-1:0]  GAIN_UNITY = 15'd1024;
  localparam logic [GAIN_W-1:0]  GAIN_MAX   = 15'd16384;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE  = 17'd65536;
  localparam logic [BIN_W-1:0]   WHITE_MIN  = 8'd128;

  typedef enum logic [1:0] {
    OP_HIST  = 2'd0,
    OP_GAIN  = 2'd1,
    OP_PIXEL = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    REG_ENABLE        = 3'd0,
    REG_BLACK_PERCENT = 3'd1,
    REG_WHITE_PERCENT = 3'd2,
    REG_BLACK_FLOOR   = 3'd3,
    REG_BLACK_CEILING = 3'd4,
    REG_WHITE_TARGET  = 3'd5,
    REG_CONTRAST_LOW  = 3'd6,
    REG_CONTRAST_HIGH = 3'd7
  } reg_idx_t;

  typedef enum logic [4:0] {
    S_IDLE, S_HIST_WR, S_PIX_MUL, S_PIX_OUT, S_SUM_RD, S_SUM_ACC,
    S_THR_GO, S_THR_WAIT, S_WALK_CHK, S_WALK_ACC, S_WG_GO, S_WG_WAIT,
    S_CLIP_GO, S_CLIP_WAIT, S_CG_GO, S_CG_WAIT, S_ALPHA_PREP, S_ALPHA_SIGN,
    S_ALPHA_GO, S_ALPHA_WAIT, S_MUL_A, S_MUL_B, S_BLEND, S_GAIN_OUT
  } state_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] gray;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } item_t;

  typedef struct packed {
    logic             enable;
    logic [PCT_W-1:0] black_percent;
    logic [PCT_W-1:0] white_percent;
    logic [7:0]       black_floor;
    logic [7:0]       black_ceiling;
    logic [PCT_W-1:0] white_target_percent;
    logic [7:0]       contrast_low;
    logic [7:0]       contrast_high;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    enable: 1'b1, black_percent: 7'd10, white_percent: 7'd99,
    black_floor: 8'd1, black_ceiling: 8'd50, white_target_percent: 7'd90,
    contrast_low: 8'd20, contrast_high: 8'd50
  };

  typedef struct packed {
    logic              kind;
    logic [7:0]        red_out;
    logic [7:0]        green_out;
    logic [7:0]        blue_out;
    logic [GAIN_W-1:0] gain_report;
    logic [7:0]        black_offset;
    logic [7:0]        white_point;
  } res_t;

  // 0.45 gamma curve
  localparam logic [7:0] GAMMA_LUT [BINS] = '{
    8'd0,8'd21,8'd28,8'd34,8'd39,8'd43,8'd47,8'd50,
    8'd53,8'd56,8'd59,8'd62,8'd64,8'd66,8'd69,8'd71,
    8'd73,8'd75,8'd77,8'd79,8'd81,8'd83,8'd84,8'd86,
    8'd88,8'd89,8'd91,8'd93,8'd94,8'd96,8'd97,8'd99,
    8'd100,8'd101,8'd103,8'd104,8'd105,8'd107,8'd108,8'd109,
    8'd111,8'd112,8'd113,8'd114,8'd115,8'd117,8'd118,8'd119,
    8'd120,8'd121,8'd122,8'd123,8'd124,8'd126,8'd127,8'd128,
    8'd129,8'd130,8'd131,8'd132,8'd133,8'd134,8'd135,8'd136,
    8'd137,8'd138,8'd139,8'd140,8'd140,8'd141,8'd142,8'd143,
    8'd144,8'd145,8'd146,8'd147,8'd148,8'd149,8'd149,8'd150,
    8'd151,8'd152,8'd153,8'd154,8'd155,8'd155,8'd156,8'd157,
    8'd158,8'd159,8'd159,8'd160,8'd161,8'd162,8'd163,8'd163,
    8'd164,8'd165,8'd166,8'd166,8'd167,8'd168,8'd169,8'd169,
    8'd170,8'd171,8'd172,8'd172,8'd173,8'd174,8'd175,8'd175,
    8'd176,8'd177,8'd177,8'd178,8'd179,8'd179,8'd180,8'd181,
    8'd182,8'd182,8'd183,8'd184,8'd184,8'd185,8'd186,8'd186,
    8'd187,8'd188,8'd188,8'd189,8'd190,8'd190,8'd191,8'd191,
    8'd192,8'd193,8'd193,8'd194,8'd195,8'd195,8'd196,8'd196,
    8'd197,8'd198,8'd198,8'd199,8'd200,8'd200,8'd201,8'd201,
    8'd202,8'd203,8'd203,8'd204,8'd204,8'd205,8'd206,8'd206,
    8'd207,8'd207,8'd208,8'd208,8'd209,8'd210,8'd210,8'd211,
    8'd211,8'd212,8'd212,8'd213,8'd214,8'd214,8'd215,8'd215,
    8'd216,8'd216,8'd217,8'd217,8'd218,8'd219,8'd219,8'd220,
    8'd220,8'd221,8'd221,8'd222,8'd222,8'd223,8'd223,8'd224,
    8'd224,8'd225,8'd225,8'd226,8'd227,8'd227,8'd228,8'd228,
    8'd229,8'd229,8'd230,8'd230,8'd231,8'd231,8'd232,8'd232,
    8'd233,8'd233,8'd234,8'd234,8'd235,8'd235,8'd236,8'd236,
    8'd237,8'd237,8'd238,8'd238,8'd239,8'd239,8'd240,8'd240,
    8'd241,8'd241,8'd242,8'd242,8'd242,8'd243,8'd243,8'd244,
    8'd244,8'd245,8'd245,8'd246,8'd246,8'd247,8'd247,8'd248,
    8'd248,8'd249,8'd249,8'd250,8'd250,8'd250,8'd251,8'd251,
    8'd252,8'd252,8'd253,8'd253,8'd254,8'd254,8'd255,8'd255
  };

endpackage

`default_nettype wire

// ----- rtl/histogram_contrast_gain_stretch_top.sv -----
// Histogram based auto contrast gain stage.
// Command channel: start/busy; a command transfers at a clock edge with start high
// and busy low. opcode 0 adds gray to the 256-bin histogram, 3 clears it, 1 computes
// the gain from the histogram and reports it, 2 applies the gain to an RGB pixel.
// Commands sit in a two-entry queue in front of the execution unit, so busy rises
// only when both entries are taken.
// Results: done marks one cycle with kind and payload; the receiver cannot stall.
// With the execution unit free, a pixel command is popped in the idle state, its
// gamma products are registered in the multiply state and done is registered from
// the output state. A histogram sample occupies the idle and write states, a clear
// only the idle state. A gain computation sums the histogram, makes two cumulative
// walks over the bins and runs three or four divisions in the shared serial
// divider; thresholds are compared without a division. With auto contrast off it
// reports unity gain straight from the idle state.
// Configuration: wr_en, wr_index, wr_data write a register; the user must do so only
// while the block is idle, as the block does not enforce it. Reset restores register
// defaults, unity gain and an empty histogram at once through per-bin valid bits.
// depends on hcg_pkg, hcg_front, hcg_back
`timescale 1ns / 1ps
`default_nettype none

module histogram_contrast_gain_stretch_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  opcode,
  input  logic [7:0]                  gray,
  input  logic [7:0]                  red,
  input  logic [7:0]                  green,
  input  logic [7:0]                  blue,
  output logic                        done,
  output logic                        kind,
  output logic [7:0]                  red_out,
  output logic [7:0]                  green_out,
  output logic [7:0]                  blue_out,
  output logic [hcg_pkg::GAIN_W-1:0]  gain_report,
  output logic [7:0]                  black_offset,
  output logic [7:0]                  white_point,
  input  logic                        wr_en,
  input  logic [2:0]                  wr_index,
  input  logic [7:0]                  wr_data
);
  import hcg_pkg::*;

  cfg_t  cfg;
  item_t head;
  logic  head_valid;
  logic  pop;
  res_t  res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (wr_en) begin
      unique case (reg_idx_t'(wr_index))
        REG_ENABLE:        cfg.enable               <= wr_data[0];
        REG_BLACK_PERCENT: cfg.black_percent        <= wr_data[PCT_W-1:0];
        REG_WHITE_PERCENT: cfg.white_percent        <= wr_data[PCT_W-1:0];
        REG_BLACK_FLOOR:   cfg.black_floor          <= wr_data;
        REG_BLACK_CEILING: cfg.black_ceiling        <= wr_data;
        REG_WHITE_TARGET:  cfg.white_target_percent <= wr_data[PCT_W-1:0];
        REG_CONTRAST_LOW:  cfg.contrast_low         <= wr_data;
        REG_CONTRAST_HIGH: cfg.contrast_high        <= wr_data;
      endcase
    end
  end

  hcg_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .opcode     (opcode),
    .gray       (gray),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .busy       (busy),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid)
  );

  hcg_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .done       (done),
    .res        (res)
  );

  assign kind         = res.kind;
  assign red_out      = res.red_out;
  assign green_out    = res.green_out;
  assign blue_out     = res.blue_out;
  assign gain_report  = res.gain_report;
  assign black_offset = res.black_offset;
  assign white_point  = res.white_point;

endmodule

`default_nettype wire

// ----- rtl/hcg_front.sv -----
// front end: takes commands, decodes the opcode and queues them for the back end
// depends on hcg_pkg
`timescale 1ns / 1ps
`default_nettype none

module hcg_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [1:0]    opcode,
  input  logic [7:0]    gray,
  input  logic [7:0]    red,
  input  logic [7:0]    green,
  input  logic [7:0]    blue,
  output logic          busy,
  input  logic          pop,
  output hcg_pkg::item_t head,
  output logic          head_valid
);
  import hcg_pkg::*;

  item_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              push;
  logic              pull;
  item_t             incoming;

  assign busy       = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];
  assign push       = start && !busy;
  assign pull       = pop && head_valid;

  always_comb begin
    incoming.op    = op_t'(opcode);
    incoming.gray  = gray;
    incoming.red   = red;
    incoming.green = green;
    incoming.blue  = blue;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pull) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pull})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/hcg_div.sv -----
// shared restoring divider, one quotient bit per cycle
// depends on hcg_pkg
`timescale 1ns / 1ps
`default_nettype none

module hcg_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [hcg_pkg::NUM_W-1:0] num,
  input  logic [hcg_pkg::DEN_W-1:0] den,
  output logic                      busy,
  output logic                      done,
  output logic [hcg_pkg::NUM_W-1:0] quot
);
  import hcg_pkg::*;

  logic [NUM_W-1:0]     q;
  logic [DEN_W-1:0]     rem;
  logic [DEN_W-1:0]     divisor;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DEN_W:0]       shifted;
  logic                 fits;

  assign quot    = q;
  assign shifted = {rem, q[NUM_W-1]};
  assign fits    = (shifted >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (start) begin
      q       <= num;
      rem     <= '0;
      divisor <= den;
    end else if (busy) begin
      q <= {q[NUM_W-2:0], fits};
      if (fits) begin
        rem <= DEN_W'(shifted - {1'b0, divisor});
      end else begin
        rem <= shifted[DEN_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(NUM_W - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/hcg_back.sv -----
// back end: histogram store, gain computation sequencer and pixel gain path
// depends on hcg_pkg and hcg_div
`timescale 1ns / 1ps
`default_nettype none

module hcg_back (
  input  logic           clk,
  input  logic           rst,
  input  hcg_pkg::cfg_t  cfg,
  input  hcg_pkg::item_t head,
  input  logic           head_valid,
  output logic           pop,
  output logic           done,
  output hcg_pkg::res_t  res
);
  import hcg_pkg::*;

  state_t state;
  state_t state_next;

  // histogram store; entries without a valid bit read as zero
  logic [COUNT_BITS-1:0] mem [BINS];
  logic [BINS-1:0]       bin_valid;
  logic [BIN_W-1:0]      raddr;
  logic [COUNT_BITS-1:0] rd_data;
  logic                  rd_vld;
  logic [COUNT_BITS-1:0] rdata;
  logic                  we;
  logic [COUNT_BITS-1:0] wdata;
  logic                  clear;

  logic [BIN_W-1:0]   bin_q;
  logic [7:0]         red_q;
  logic [7:0]         green_q;
  logic [7:0]         blue_q;
  logic [22:0]        pix_r;
  logic [22:0]        pix_g;
  logic [22:0]        pix_b;

  logic [TOTAL_W-1:0] total;
  logic [TOTAL_W-1:0] cum;
  logic [THR_W-1:0]   thr;
  logic [THR_W-1:0]   cum_scaled;
  logic [BIN_W-1:0]   idx;
  logic [BIN_W-1:0]   ceil_idx;
  logic [BIN_W-1:0]   white;
  logic [BIN_W-1:0]   off;
  logic [BIN_W-1:0]   off_clip;
  logic               walk_black;
  logic               walk_step;

  logic [GAIN_W-1:0]  wg;
  logic [GAIN_W-1:0]  clipg;
  logic [GAIN_W-1:0]  blend;
  logic [GAIN_W-1:0]  gain;
  logic [GAIN_W-1:0]  gain_sel;
  logic [CG_W-1:0]    cg;
  logic [ALPHA_W-1:0] alpha;
  logic [15:0]        hi_black;
  logic signed [8:0]  contrast_diff;
  logic signed [17:0] anum_s;
  logic signed [17:0] aden_s;
  logic signed [17:0] n_fix;
  logic signed [17:0] d_fix;
  logic [15:0]        anum;
  logic [15:0]        aden;
  logic [35:0]        prod_a;
  logic [31:0]        prod_b;
  logic [36:0]        blend_sum;
  logic [20:0]        blend_raw;

  logic               div_start;
  logic               div_busy;
  logic               div_done;
  logic [NUM_W-1:0]   div_num;
  logic [DEN_W-1:0]   div_den;
  logic [NUM_W-1:0]   div_quot;

  function automatic logic [7:0] sat8(input logic [22:0] p);
    logic [12:0] s;
    s = p[22:10];
    return (s > 13'd255) ? 8'd255 : s[7:0];
  endfunction

  hcg_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign rdata     = rd_vld ? rd_data : '0;
  assign we        = (state == S_HIST_WR);
  assign wdata     = (rdata == '1) ? rdata : rdata + 1'b1;
  assign clear     = (state == S_IDLE) && head_valid && (head.op == OP_CLEAR);
  // cum >= floor(pct * total / 100) is the same as 100 * cum + 99 >= pct * total
  assign cum_scaled = THR_W'(cum) * THR_W'(PCT_SCALE) + THR_W'(PCT_SCALE - 1);
  assign walk_step = (idx > ceil_idx) || ((cum_scaled >= thr) && (idx > 8'd1));
  // the black index sits in idx once both walks are over
  assign hi_black  = cfg.contrast_high * idx;
  assign contrast_diff = $signed({1'b0, cfg.contrast_low}) - $signed({1'b0, cfg.contrast_high});
  assign blend_sum = {1'b0, prod_a} + 37'(prod_b);
  assign blend_raw = blend_sum[36:16];

  always_comb begin
    priority if (idx < cfg.black_floor) begin
      off_clip = cfg.black_floor;
    end else if (idx > cfg.black_ceiling) begin
      off_clip = cfg.black_ceiling;
    end else begin
      off_clip = idx;
    end
  end

  always_comb begin
    if (aden_s < 0) begin
      n_fix = -anum_s;
      d_fix = -aden_s;
    end else begin
      n_fix = anum_s;
      d_fix = aden_s;
    end
  end

  always_comb begin
    priority if (cg < CG_W'(wg)) begin
      gain_sel = wg;
    end else if (cg > CG_W'(blend)) begin
      gain_sel = blend;
    end else begin
      gain_sel = cg[GAIN_W-1:0];
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    div_start  = 1'b0;
    div_num    = '0;
    div_den    = '0;
    raddr      = idx;
    unique case (state)
      S_IDLE: begin
        if (head_valid) begin
          pop = 1'b1;
          unique case (head.op)
            OP_HIST: begin
              raddr      = head.gray;
              state_next = S_HIST_WR;
            end
            OP_PIXEL: state_next = S_PIX_MUL;
            OP_CLEAR: state_next = S_IDLE;
            OP_GAIN:  state_next = cfg.enable ? S_SUM_RD : S_IDLE;
          endcase
        end
      end
      S_HIST_WR: state_next = S_IDLE;
      S_PIX_MUL: state_next = S_PIX_OUT;
      S_PIX_OUT: state_next = S_IDLE;
      S_SUM_RD:  state_next = S_SUM_ACC;
      S_SUM_ACC: state_next = (idx == '0) ? S_THR_GO : S_SUM_RD;
      S_THR_GO:  state_next = S_THR_WAIT;
      S_THR_WAIT: state_next = S_WALK_CHK;
      S_WALK_CHK: begin
        priority if (walk_step) begin
          state_next = S_WALK_ACC;
        end else if (walk_black) begin
          state_next = S_WG_GO;
        end else begin
          state_next = S_THR_GO;
        end
      end
      S_WALK_ACC: state_next = S_WALK_CHK;
      S_WG_GO: begin
        div_start  = 1'b1;
        div_num    = NUM_W'({cfg.white_target_percent, 18'd0});
        div_den    = DEN_W'(PCT_SCALE) * DEN_W'(white);
        state_next = S_WG_WAIT;
      end
      S_WG_WAIT: state_next = div_done ? S_CLIP_GO : S_WG_WAIT;
      S_CLIP_GO: begin
        div_start  = 1'b1;
        div_num    = NUM_W'(CLIP_NUM);
        div_den    = DEN_W'(PCT_SCALE) * DEN_W'(white);
        state_next = S_CLIP_WAIT;
      end
      S_CLIP_WAIT: state_next = div_done ? S_CG_GO : S_CLIP_WAIT;
      S_CG_GO: begin
        div_start  = 1'b1;
        div_num    = NUM_W'(CG_NUM);
        div_den    = DEN_W'(9'd256 - {1'b0, off});
        state_next = S_CG_WAIT;
      end
      S_CG_WAIT: state_next = div_done ? S_ALPHA_PREP : S_CG_WAIT;
      S_ALPHA_PREP: begin
        state_next = (cfg.contrast_low == cfg.contrast_high) ? S_MUL_A : S_ALPHA_SIGN;
      end
      S_ALPHA_SIGN: begin
        state_next = ((n_fix <= 0) || (n_fix >= d_fix)) ? S_MUL_A : S_ALPHA_GO;
      end
      S_ALPHA_GO: begin
        div_start  = 1'b1;
        div_num    = NUM_W'({anum, 16'd0});
        div_den    = aden;
        state_next = S_ALPHA_WAIT;
      end
      S_ALPHA_WAIT: state_next = div_done ? S_MUL_A : S_ALPHA_WAIT;
      S_MUL_A:      state_next = S_MUL_B;
      S_MUL_B:      state_next = S_BLEND;
      S_BLEND:      state_next = S_GAIN_OUT;
      S_GAIN_OUT:   state_next = S_IDLE;
      default:      state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[bin_q] <= wdata;
    end
    rd_data <= mem[raddr];
    rd_vld  <= bin_valid[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      done      <= 1'b0;
      gain      <= GAIN_UNITY;
      bin_valid <= '0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      if (clear) begin
        bin_valid <= '0;
      end else if (we) begin
        bin_valid[bin_q] <= 1'b1;
      end
      if (state == S_PIX_OUT || state == S_GAIN_OUT) begin
        done <= 1'b1;
      end
      if (state == S_IDLE && head_valid && head.op == OP_GAIN && !cfg.enable) begin
        done <= 1'b1;
        gain <= GAIN_UNITY;
      end
      if (state == S_GAIN_OUT) begin
        gain <= gain_sel;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        bin_q   <= head.gray;
        red_q   <= head.red;
        green_q <= head.green;
        blue_q  <= head.blue;
        idx        <= 8'd255;
        total      <= '0;
        walk_black <= 1'b0;
        if (head_valid && head.op == OP_GAIN && !cfg.enable) begin
          res <= '{kind: 1'b1, red_out: 8'd0, green_out: 8'd0, blue_out: 8'd0,
                   gain_report: GAIN_UNITY, black_offset: 8'd0, white_point: 8'd0};
        end
      end
      S_PIX_MUL: begin
        pix_r <= GAMMA_LUT[red_q] * gain;
        pix_g <= GAMMA_LUT[green_q] * gain;
        pix_b <= GAMMA_LUT[blue_q] * gain;
      end
      S_PIX_OUT: begin
        res <= '{kind: 1'b0, red_out: sat8(pix_r), green_out: sat8(pix_g),
                 blue_out: sat8(pix_b), gain_report: '0, black_offset: 8'd0,
                 white_point: 8'd0};
      end
      S_SUM_ACC: begin
        total <= total + TOTAL_W'(rdata);
        idx   <= idx - 1'b1;
      end
      S_THR_GO: begin
        thr <= {{TOTAL_W{1'b0}}, (walk_black ? cfg.black_percent : cfg.white_percent)}
               * {{PCT_W{1'b0}}, total};
      end
      S_THR_WAIT: begin
        idx      <= 8'd255;
        cum      <= total;
        ceil_idx <= walk_black ? white : 8'd255;
      end
      S_WALK_CHK: begin
        // the black walk first steps down to the white index unconditionally
        if (!walk_step) begin
          if (walk_black) begin
            off <= off_clip;
          end else begin
            white      <= (idx <= WHITE_MIN) ? WHITE_MIN : idx;
            walk_black <= 1'b1;
          end
        end
      end
      S_WALK_ACC: begin
        cum <= cum - TOTAL_W'(rdata);
        idx <= idx - 1'b1;
      end
      S_WG_WAIT: begin
        if (div_done) begin
          wg <= div_quot[GAIN_W-1:0];
        end
      end
      S_CLIP_WAIT: begin
        if (div_done) begin
          clipg <= div_quot[GAIN_W-1:0];
        end
      end
      S_CG_WAIT: begin
        if (div_done) begin
          cg <= div_quot[CG_W-1:0];
        end
      end
      S_ALPHA_PREP: begin
        alpha  <= ALPHA_ONE;
        anum_s <= $signed({10'd0, white} - {2'd0, hi_black});
        aden_s <= contrast_diff * $signed({1'b0, idx});
      end
      S_ALPHA_SIGN: begin
        priority if (n_fix <= 0) begin
          alpha <= '0;
        end else if (n_fix >= d_fix) begin
          alpha <= ALPHA_ONE;
        end else begin
          anum <= n_fix[15:0];
          aden <= d_fix[15:0];
        end
      end
      S_ALPHA_WAIT: begin
        if (div_done) begin
          alpha <= div_quot[ALPHA_W-1:0];
        end
      end
      S_MUL_A: prod_a <= alpha * cg;
      S_MUL_B: prod_b <= (ALPHA_ONE - alpha) * clipg;
      S_BLEND: begin
        blend <= (blend_raw > 21'(GAIN_MAX)) ? GAIN_MAX : blend_raw[GAIN_W-1:0];
      end
      S_GAIN_OUT: begin
        res <= '{kind: 1'b1, red_out: 8'd0, green_out: 8'd0, blue_out: 8'd0,
                 gain_report: gain_sel, black_offset: off, white_point: white};
      end
      default: begin
      end
    endcase
  end

  a_pixel_report_zero: assert property (@(posedge clk) disable iff (rst)
    done && !res.kind |-> res.gain_report == '0 && res.black_offset == '0
                          && res.white_point == '0)
    else $error("pixel result carries gain report fields");

  a_report_color_zero: assert property (@(posedge clk) disable iff (rst)
    done && res.kind |-> res.red_out == '0 && res.green_out == '0 && res.blue_out == '0)
    else $error("gain report carries color fields");

  a_gain_range: assert property (@(posedge clk) disable iff (rst)
    gain <= GAIN_MAX)
    else $error("stored gain above 16.0");

  a_div_idle_start: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == S_PIX_OUT || $past(state) == S_GAIN_OUT
             || $past(state) == S_IDLE)
    else $error("result strobe from an unexpected state");

endmodule

`default_nettype wire
